// ===== src/fcw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcw_pkg: shared types and constants of the flow color wheel
// Field layouts, wheel ramp lengths, fixed-point widths and the CORDIC angle
// table used by the front end, the queue and the color back end.
// ----------------------------------------------------------------------------
package fcw_pkg;

  localparam int WHEEL_SIZE = 55;
  localparam int WHEEL_W    = $clog2(WHEEL_SIZE);

  localparam int LEN_A = 15;
  localparam int LEN_B = 6;
  localparam int LEN_C = 4;
  localparam int LEN_D = 11;
  localparam int LEN_E = 13;
  localparam int LEN_F = 6;

  localparam int FLOW_W       = 24;
  localparam int RANGE_W      = 16;
  localparam int PROD_W       = FLOW_W + RANGE_W + 1;
  localparam int MAG_W        = 21;
  localparam int SQ_W         = 2 * MAG_W;
  localparam int SUM_W        = SQ_W + 1;
  localparam int ROOT_W       = MAG_W;
  localparam int VEC_W        = 35;
  localparam int ANG_W        = 18;
  localparam int PHASE_W      = 17;
  localparam int FK_W         = PHASE_W + WHEEL_W;
  localparam int CORDIC_STEPS = 14;
  localparam int SQRT_STEPS   = 21;
  localparam int FIFO_DEPTH   = 4;

  localparam logic [RANGE_W-1:0] INV_RANGE_RST = 16'd4096;
  localparam logic [SUM_W-1:0]   UNIT_SQ       = SUM_W'(1) << 40;

  localparam logic [PHASE_W-1:0] PH_NEG_PI  = 17'd65536;
  localparam logic [PHASE_W-1:0] PH_ZERO    = 17'd32768;
  localparam logic [PHASE_W-1:0] PH_POS_Q   = 17'd49152;
  localparam logic [PHASE_W-1:0] PH_NEG_Q   = 17'd16384;
  localparam logic signed [ANG_W-1:0] ANG_HALF = 18'sd32768;
  localparam logic signed [ANG_W-1:0] ANG_FULL = 18'sd65536;

  // Configuration register word index.
  typedef enum logic [0:0] {
    REG_INV_RANGE = 1'b0
  } fcw_reg_e;

  typedef struct packed {
    logic signed [FLOW_W-1:0] flow_x;
    logic signed [FLOW_W-1:0] flow_y;
    logic                     invalid;
  } fcw_in_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } fcw_out_t;

  // Classified request handed from the front end to the back end.
  typedef struct packed {
    logic                     invalid;
    logic                     near_unit;
    logic [MAG_W-1:0]         mag_a;
    logic [MAG_W-1:0]         mag_b;
    logic signed [FLOW_W-1:0] flow_x;
    logic signed [FLOW_W-1:0] flow_y;
  } fcw_job_t;

  function automatic logic signed [ANG_W-1:0] atan_step(int i);
    logic signed [ANG_W-1:0] a;
    case (i)
      0:       a = 18'sd8192;
      1:       a = 18'sd4836;
      2:       a = 18'sd2555;
      3:       a = 18'sd1297;
      4:       a = 18'sd651;
      5:       a = 18'sd326;
      6:       a = 18'sd163;
      7:       a = 18'sd81;
      8:       a = 18'sd41;
      9:       a = 18'sd20;
      10:      a = 18'sd10;
      11:      a = 18'sd5;
      12:      a = 18'sd3;
      13:      a = 18'sd1;
      default: a = '0;
    endcase
    return a;
  endfunction

  // Wheel color of entry k, index 0 red, 1 green, 2 blue. Only called with
  // constant arguments, so it folds into a table at elaboration.
  function automatic logic [2:0][7:0] wheel_calc(int k);
    logic [2:0][7:0] c;
    int j;
    c = '0;
    c[0] = 8'd255;
    j = k;
    if (j < LEN_A) begin
      c[1] = 8'(255 * j / LEN_A);
    end else begin
      j = j - LEN_A;
      if (j < LEN_B) begin
        c[0] = 8'(255 - 255 * j / LEN_B);
        c[1] = 8'd255;
      end else begin
        j = j - LEN_B;
        if (j < LEN_C) begin
          c[0] = 8'd0;
          c[1] = 8'd255;
          c[2] = 8'(255 * j / LEN_C);
        end else begin
          j = j - LEN_C;
          if (j < LEN_D) begin
            c[0] = 8'd0;
            c[1] = 8'(255 - 255 * j / LEN_D);
            c[2] = 8'd255;
          end else begin
            j = j - LEN_D;
            if (j < LEN_E) begin
              c[0] = 8'(255 * j / LEN_E);
              c[2] = 8'd255;
            end else begin
              j = j - LEN_E;
              if (j < LEN_F) begin
                c[2] = 8'(255 - 255 * j / LEN_F);
              end
            end
          end
        end
      end
    end
    return c;
  endfunction

endpackage

// ===== src/flow_vector_color_wheel.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flow_vector_color_wheel: optical flow vector to RGB color
// Maps each flow vector onto a 55-entry color wheel with radius fading.
// ----------------------------------------------------------------------------
// Usage: one flow vector per request on the input channel (valid/ready), one
// RGB request per input on the output channel, in order. The inverse range
// register (word 0 of the APB port) scales vectors; write it while idle.
// The path from input to output valid runs through 29 register stages: one
// intake stage, one queue stage, one squaring stage, 22 stages of square
// root with CORDIC running alongside, then phase, lookup, blend and output
// stages.
// Throughput is one request per cycle while the output is not stalled; the
// 21-step square root and 14-step CORDIC are unrolled across pipeline stages.
// A four-entry queue separates intake from the color pipeline, so new
// requests are still accepted while the output is stalled until the queue
// fills. When the receiver stalls, the color pipeline holds in place and the
// output request stays stable.
// Reset clears all valid state and sets inverse range to 4096 (1.0 in Q4.12).
// ----------------------------------------------------------------------------
module flow_vector_color_wheel (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  fcw_pkg::fcw_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output fcw_pkg::fcw_out_t out_data_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import fcw_pkg::*;

  logic [RANGE_W-1:0] inv_range_q;
  logic               sel_inv;
  logic               job_valid, job_ready, q_valid, q_ready;
  fcw_job_t           job, q_job;

  assign pready  = 1'b1;
  assign sel_inv = (fcw_reg_e'(paddr[2]) == REG_INV_RANGE);
  assign prdata  = sel_inv ? {16'd0, inv_range_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_range_q <= INV_RANGE_RST;
    end else if (psel && penable && pwrite && pready && sel_inv) begin
      inv_range_q <= pwdata[RANGE_W-1:0];
    end
  end

  fcw_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .inv_range_i (inv_range_q),
    .job_valid_o (job_valid),
    .job_ready_i (job_ready),
    .job_o       (job)
  );

  fcw_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (job_valid),
    .push_ready_o (job_ready),
    .push_data_i  (job),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (q_job)
  );

  fcw_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (q_valid),
    .job_ready_o (q_ready),
    .job_i       (q_job),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== src/fcw_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcw_front: request intake and classification
// Scales each flow vector by the inverse range and marks whether the scaled
// vector can lie inside the unit radius.
// ----------------------------------------------------------------------------
module fcw_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  fcw_pkg::fcw_in_t              in_data_i,
  input  logic [fcw_pkg::RANGE_W-1:0]   inv_range_i,
  output logic                          job_valid_o,
  input  logic                          job_ready_i,
  output fcw_pkg::fcw_job_t             job_o
);
  import fcw_pkg::*;

  logic                     valid_q;
  logic                     invalid_q;
  logic signed [FLOW_W-1:0] fx_q, fy_q;
  logic signed [PROD_W-1:0] prod_a_q, prod_b_q;
  logic signed [PROD_W-1:0] prod_a_d, prod_b_d;
  logic signed [RANGE_W:0]  inv_s;
  logic [PROD_W-1:0]        abs_a, abs_b;
  logic                     near_unit;

  assign inv_s    = signed'({1'b0, inv_range_i});
  assign prod_a_d = in_data_i.flow_y * inv_s;
  assign prod_b_d = in_data_i.flow_x * inv_s;

  assign in_ready_o = !valid_q || job_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      invalid_q <= in_data_i.invalid;
      fx_q      <= in_data_i.flow_x;
      fy_q      <= in_data_i.flow_y;
      prod_a_q  <= prod_a_d;
      prod_b_q  <= prod_b_d;
    end
  end

  always_comb begin
    abs_a = prod_a_q[PROD_W-1] ? PROD_W'(-prod_a_q) : PROD_W'(prod_a_q);
    abs_b = prod_b_q[PROD_W-1] ? PROD_W'(-prod_b_q) : PROD_W'(prod_b_q);
    // A component of 2^21 or more is outside the unit radius on its own.
    near_unit = (abs_a[PROD_W-1:MAG_W] == '0) && (abs_b[PROD_W-1:MAG_W] == '0);
    job_o.invalid   = invalid_q;
    job_o.near_unit = near_unit;
    job_o.mag_a     = near_unit ? abs_a[MAG_W-1:0] : '0;
    job_o.mag_b     = near_unit ? abs_b[MAG_W-1:0] : '0;
    job_o.flow_x    = fx_q;
    job_o.flow_y    = fy_q;
  end

  assign job_valid_o = valid_q;

endmodule

// ===== src/fcw_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcw_fifo: request queue between front end and back end
// A small first-in first-out buffer so both sides can stall independently.
// ----------------------------------------------------------------------------
module fcw_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  fcw_pkg::fcw_job_t push_data_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output fcw_pkg::fcw_job_t pop_data_o
);
  import fcw_pkg::*;

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  fcw_job_t         mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             push, pop;

  assign push_ready_o = (count_q != CNT_W'(FIFO_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= PTR_W'(wr_ptr_q + 1'b1);
      end
      if (pop) begin
        rd_ptr_q <= PTR_W'(rd_ptr_q + 1'b1);
      end
      if (push && !pop) begin
        count_q <= CNT_W'(count_q + 1'b1);
      end else if (pop && !push) begin
        count_q <= CNT_W'(count_q - 1'b1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== src/fcw_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcw_back: color computation pipeline
// Squares, unrolled square root and CORDIC angle in parallel stages, then
// wheel lookup, blending and saturation into the output register.
// ----------------------------------------------------------------------------
module fcw_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              job_valid_i,
  output logic              job_ready_o,
  input  fcw_pkg::fcw_job_t job_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output fcw_pkg::fcw_out_t out_data_o
);
  import fcw_pkg::*;

  typedef struct packed {
    logic                    invalid;
    logic                    in_unit;
    logic                    special;
    logic [PHASE_W-1:0]      sphase;
    logic [SUM_W-1:0]        rem;
    logic [SUM_W-1:0]        root;
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic signed [ANG_W-1:0] z;
  } bk_stage_t;

  logic en;

  // Stage A: squares and CORDIC setup.
  logic             va_q;
  bk_stage_t        a_q, a_d;
  logic [SQ_W-1:0]  sq_a_q, sq_b_q;

  // Square root and CORDIC iterations.
  logic             vs_q [SQRT_STEPS+1];
  bk_stage_t        st_q [SQRT_STEPS+1];
  bk_stage_t        st_d [SQRT_STEPS+1];
  logic [SUM_W-1:0] sum;

  // Tail stages.
  logic                vc_q, vd_q, ve_q, vf_q;
  logic                inv_c_q, inv_d_q, inv_e_q;
  logic                in_c_q, in_d_q, in_e_q;
  logic [ROOT_W-1:0]   r_c_q, r_d_q, r_e_q;
  logic [PHASE_W-1:0]  ph_c_q;
  logic [PHASE_W-1:0]  ph_d;
  logic signed [ANG_W-1:0] zw;
  logic [FK_W-1:0]     fkq;
  logic [FK_W-17:0]    k_raw;
  logic [WHEEL_W-1:0]  k0, k1;
  logic [2:0][7:0]     c0_q, c1_q;
  logic [7:0]          f_q;
  logic [2:0][15:0]    blend_d, blend_q;
  logic [2:0][7:0]     col_d;
  fcw_out_t            out_q;
  logic [2:0][7:0]     wheel_tbl [WHEEL_SIZE];

  assign en          = !vf_q || out_ready_i;
  assign job_ready_o = en;

  for (genvar g = 0; g < WHEEL_SIZE; g++) begin : g_wheel
    assign wheel_tbl[g] = wheel_calc(g);
  end

  always_comb begin
    a_d = '0;
    a_d.invalid = job_i.invalid;
    a_d.in_unit = job_i.near_unit;
    a_d.x = VEC_W'(job_i.flow_y) <<< 8;
    a_d.y = VEC_W'(job_i.flow_x) <<< 8;
    if (a_d.x < 0) begin
      a_d.x = -a_d.x;
      a_d.y = -a_d.y;
      a_d.z = ANG_HALF;
    end
    // Axis directions skip CORDIC and use exact phases.
    if (job_i.flow_x == '0) begin
      a_d.special = 1'b1;
      a_d.sphase  = (job_i.flow_y < 0) ? PH_NEG_PI : PH_ZERO;
    end else if (job_i.flow_y == '0) begin
      a_d.special = 1'b1;
      a_d.sphase  = (job_i.flow_x > 0) ? PH_POS_Q : PH_NEG_Q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (en) begin
      va_q <= job_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_q    <= a_d;
      sq_a_q <= job_i.mag_a * job_i.mag_a;
      sq_b_q <= job_i.mag_b * job_i.mag_b;
    end
  end

  always_comb begin
    sum = SUM_W'(sq_a_q) + SUM_W'(sq_b_q);
    st_d[0]         = a_q;
    st_d[0].rem     = sum;
    st_d[0].root    = '0;
    st_d[0].in_unit = a_q.in_unit && (sum <= UNIT_SQ);
  end

  for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_step
    localparam logic [SUM_W-1:0] BIT = SUM_W'(1) << (2 * (SQRT_STEPS - 1 - g));
    always_comb begin
      st_d[g+1] = st_q[g];
      if (st_q[g].rem >= st_q[g].root + BIT) begin
        st_d[g+1].rem  = st_q[g].rem - (st_q[g].root + BIT);
        st_d[g+1].root = (st_q[g].root >> 1) + BIT;
      end else begin
        st_d[g+1].root = st_q[g].root >> 1;
      end
      if (g < CORDIC_STEPS) begin
        if (st_q[g].y > 0) begin
          st_d[g+1].x = st_q[g].x + (st_q[g].y >>> g);
          st_d[g+1].y = st_q[g].y - (st_q[g].x >>> g);
          st_d[g+1].z = st_q[g].z + atan_step(g);
        end else begin
          st_d[g+1].x = st_q[g].x - (st_q[g].y >>> g);
          st_d[g+1].y = st_q[g].y + (st_q[g].x >>> g);
          st_d[g+1].z = st_q[g].z - atan_step(g);
        end
      end
    end
  end

  for (genvar g = 0; g <= SQRT_STEPS; g++) begin : g_stage
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vs_q[g] <= 1'b0;
      end else if (en) begin
        vs_q[g] <= (g == 0) ? va_q : vs_q[(g == 0) ? 0 : g - 1];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        st_q[g] <= st_d[g];
      end
    end
  end

  // Stage C: fold the CORDIC angle into a phase with zero at minus pi.
  always_comb begin
    zw = st_q[SQRT_STEPS].z;
    if (zw > ANG_HALF) begin
      zw = zw - ANG_FULL;
    end else if (zw <= -ANG_HALF) begin
      zw = zw + ANG_FULL;
    end
    ph_d = st_q[SQRT_STEPS].special ? st_q[SQRT_STEPS].sphase
                                    : PHASE_W'(zw + ANG_HALF);
  end

  // Stage D: wheel position and table lookup.
  always_comb begin
    fkq   = FK_W'(ph_c_q) * FK_W'(WHEEL_SIZE - 1);
    k_raw = fkq[FK_W-1:16];
    k0    = (k_raw >= (FK_W-16)'(WHEEL_SIZE - 1)) ? WHEEL_W'(WHEEL_SIZE - 1)
                                                 : k_raw[WHEEL_W-1:0];
    k1    = (k0 == WHEEL_W'(WHEEL_SIZE - 1)) ? '0 : WHEEL_W'(k0 + 1'b1);
  end

  // Stage E: blend; stage F: saturation and radius fade.
  always_comb begin
    for (int b = 0; b < 3; b++) begin
      blend_d[b] = 16'((17'd256 - 17'(f_q)) * 17'(c0_q[b]) + 17'(f_q) * 17'(c1_q[b]));
    end
  end

  always_comb begin
    logic [36:0] fade;
    logic [17:0] dim;
    col_d = '0;
    for (int b = 0; b < 3; b++) begin
      fade = (37'd255 << 28) - 37'(r_e_q) * 37'(16'd65280 - blend_q[b]);
      dim  = 18'(blend_q[b]) * 18'd3;
      if (inv_e_q) begin
        col_d[b] = 8'd0;
      end else if (in_e_q) begin
        col_d[b] = fade[35:28];
      end else begin
        col_d[b] = dim[17:10];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 1'b0;
      vd_q <= 1'b0;
      ve_q <= 1'b0;
      vf_q <= 1'b0;
    end else if (en) begin
      vc_q <= vs_q[SQRT_STEPS];
      vd_q <= vc_q;
      ve_q <= vd_q;
      vf_q <= ve_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      inv_c_q <= st_q[SQRT_STEPS].invalid;
      in_c_q  <= st_q[SQRT_STEPS].in_unit;
      r_c_q   <= st_q[SQRT_STEPS].root[ROOT_W-1:0];
      ph_c_q  <= ph_d;
      inv_d_q <= inv_c_q;
      in_d_q  <= in_c_q;
      r_d_q   <= r_c_q;
      c0_q    <= wheel_tbl[k0];
      c1_q    <= wheel_tbl[k1];
      f_q     <= fkq[15:8];
      inv_e_q <= inv_d_q;
      in_e_q  <= in_d_q;
      r_e_q   <= r_d_q;
      blend_q <= blend_d;
      out_q.red   <= col_d[0];
      out_q.green <= col_d[1];
      out_q.blue  <= col_d[2];
    end
  end

  assign out_valid_o = vf_q;
  assign out_data_o  = out_q;

endmodule

// ===== src/fcw_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcw_checker: port-level checks of the flow color wheel
// Watches reset behavior, output holding and register read-back.
// ----------------------------------------------------------------------------
module fcw_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input fcw_pkg::fcw_out_t out_data_o,
  input logic              psel,
  input logic              penable,
  input logic              pwrite,
  input logic [2:0]        paddr,
  input logic [31:0]       pwdata,
  input logic [31:0]       prdata,
  input logic              pready
);
  import fcw_pkg::*;

  // A clock edge seen in reset leaves no output request at the next edge.
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("output valid after reset");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output request changed");

  // A write to the range register is visible on the next read of it.
  a_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && pready && (paddr[2] == REG_INV_RANGE)
    ##1 (paddr[2] == REG_INV_RANGE) && !(psel && penable && pwrite)
    |-> prdata == {16'd0, $past(pwdata[15:0])})
    else $error("inverse range read-back mismatch");

endmodule

bind flow_vector_color_wheel fcw_checker u_fcw_checker (.*);
